### hw/rtl/sdwq_pkg.sv
`default_nettype none
package sdwq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  // most entries woken by one tick
  localparam int WAKE_LIMIT      = 16;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_SLEEP = 1'b1;

  localparam logic KIND_WAKE = 1'b0;
  localparam logic KIND_ANS  = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_YIELD    = 3'd1;
  localparam logic [2:0] ST_NEGATIVE = 3'd2;
  localparam logic [2:0] ST_IDLE_THR = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic               mode;
    logic [7:0]         thread_id;
    logic signed [31:0] sleep_ticks;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] woken_or_req_id;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [63:0] deadline;
    logic [7:0]  thread;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic take;       // latch input item
    logic tick_inc;   // advance tick count
    logic calc_dl;    // deadline, tail slot
    logic rd_prev;    // read entry before insert slot
    logic shift;      // move read entry up one slot
    logic ins;        // write new entry at insert slot
    logic rd_head;    // read queue front
    logic pop;        // drop front, keep its id as pending
    logic emit_ans;   // answer to sleep request
    logic emit_wake;  // pending woken id
    logic emit_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       is_sleep;
    logic [2:0] sleep_code;
    logic       count_zero;
    logic       pos_zero;
    logic       rd_le;     // read deadline <= new deadline
    logic       due;       // read deadline <= tick count
    logic       out_free;
  } stat_t;

endpackage
`default_nettype wire

### hw/rtl/sleep_deadline_wakeup_queue.sv
`default_nettype none
// Sorted timer wake-up queue. Keeps a 64-bit count of tick items and up
// to QUEUE_DEPTH sleeping threads ordered by wake deadline, held in a
// circular buffer in one RAM. A sleep request (mode 1) always gets exactly one
// answer: yield for zero ticks, ignored for negative ticks or for the
// configured idle thread, full when the queue is full, otherwise the thread
// is queued at now + ticks (saturating), behind all entries with an equal or
// earlier deadline. A tick (mode 0) advances the count, then wakes due
// entries front first, up to 16 per tick, with last set on the final one; a
// tick that wakes nothing gives no result. One item is worked at a time:
// a queued request walks down from the tail past each entry with a later
// deadline (each step is one RAM read then one write), and a tick reads
// the front once per woken thread, stopping at an entry not yet due.
// Any step that emits a result waits while out_stall holds the output
// register full. The output register lets a result wait for the consumer
// while the next item is taken. Configure idle_thread_id (cfg_we,
// cfg_data) only while the block is idle.
module sleep_deadline_wakeup_queue #(
  parameter int QUEUE_DEPTH = sdwq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // input item channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sdwq_pkg::in_item_t  in_data,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sdwq_pkg::out_item_t      out_data,
  // idle_thread_id register
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_data
);

  sdwq_pkg::cmd_t  cmd;
  sdwq_pkg::stat_t st;

  // sequencer: decode, insert walk, wake loop, transfer hand-off
  sdwq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .st      (st),
    .cmd     (cmd)
  );

  // tick count, queue RAM and pointers, output register
  sdwq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .out_data (out_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .st       (st)
  );

endmodule
`default_nettype wire

### hw/rtl/sdwq_ram.sv
`default_nettype none
module sdwq_ram #(
  parameter int WIDTH  = 72,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sdwq_ctrl.sv
`default_nettype none
module sdwq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire sdwq_pkg::stat_t st,
  output sdwq_pkg::cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_ANS  = 3'd2;
  localparam logic [2:0] S_IPOS = 3'd3;
  localparam logic [2:0] S_ICMP = 3'd4;
  localparam logic [2:0] S_WCHK = 3'd5;
  localparam logic [2:0] S_WCMP = 3'd6;
  localparam logic [2:0] S_WEND = 3'd7;

  localparam int NW = $clog2(sdwq_pkg::WAKE_LIMIT + 1);

  logic [2:0]    state, state_next;
  logic [NW-1:0] n, n_next;
  logic          pend, pend_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    n_next     = n;
    pend_next  = pend;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (!st.is_sleep) begin
          cmd.tick_inc = 1'b1;
          n_next       = '0;
          pend_next    = 1'b0;
          state_next   = S_WCHK;
        end else if (st.sleep_code != sdwq_pkg::ST_OK) begin
          state_next = S_ANS;
        end else begin
          cmd.calc_dl = 1'b1;
          state_next  = S_IPOS;
        end
      end
      S_ANS: begin
        if (st.out_free) begin
          cmd.emit_ans = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_IPOS: begin
        if (st.pos_zero) begin
          cmd.ins    = 1'b1;
          state_next = S_ANS;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_ICMP;
        end
      end
      S_ICMP: begin
        if (st.rd_le) begin
          cmd.ins    = 1'b1;
          state_next = S_ANS;
        end else begin
          cmd.shift  = 1'b1;
          state_next = S_IPOS;
        end
      end
      S_WCHK: begin
        if (!st.count_zero && (n < NW'(sdwq_pkg::WAKE_LIMIT))) begin
          cmd.rd_head = 1'b1;
          state_next  = S_WCMP;
        end else begin
          state_next = S_WEND;
        end
      end
      S_WCMP: begin
        if (!st.due) begin
          state_next = S_WEND;
        end else if (!pend || st.out_free) begin
          // a further due entry: the held one is not the last
          cmd.emit_wake = pend;
          cmd.emit_last = 1'b0;
          cmd.pop       = 1'b1;
          pend_next     = 1'b1;
          n_next        = n + 1'b1;
          state_next    = S_WCHK;
        end
      end
      S_WEND: begin
        if (!pend) begin
          state_next = S_IDLE;
        end else if (st.out_free) begin
          cmd.emit_wake = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      n     <= n_next;
      pend  <= pend_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sdwq_dp.sv
`default_nettype none
module sdwq_dp #(
  parameter int QUEUE_DEPTH = sdwq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sdwq_pkg::in_item_t  in_data,
  output sdwq_pkg::out_item_t      out_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_data,
  input  wire sdwq_pkg::cmd_t      cmd,
  output sdwq_pkg::stat_t          st
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int EW = $bits(sdwq_pkg::entry_t);

  logic [63:0]        tick_count;
  logic [CW-1:0]      count;
  logic [AW-1:0]      head;
  logic [7:0]         idle_id;
  sdwq_pkg::in_item_t req;
  logic               queued;   // request went into the queue
  logic [63:0]        new_dl;
  logic [CW-1:0]      pos;
  logic [AW-1:0]      pos_phys;
  logic [7:0]         pend_id;

  sdwq_pkg::entry_t rd_entry, wr_entry;
  logic [EW-1:0]    rdata;
  logic [AW-1:0]    raddr, prev_phys, head_inc, tail;
  logic [SW-1:0]    tail_sum;
  logic [64:0]      dl_sum;
  logic [2:0]       code;

  assign rd_entry = sdwq_pkg::entry_t'(rdata);

  assign head_inc  = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign prev_phys = (pos_phys == '0) ? AW'(QUEUE_DEPTH - 1) : pos_phys - 1'b1;
  assign tail_sum  = SW'(head) + SW'(count);
  assign tail      = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                    : AW'(tail_sum);
  assign dl_sum    = {1'b0, tick_count} + {33'd0, req.sleep_ticks};

  always_comb begin
    if (req.sleep_ticks == '0) begin
      code = sdwq_pkg::ST_YIELD;
    end else if (req.sleep_ticks[31]) begin
      code = sdwq_pkg::ST_NEGATIVE;
    end else if (req.thread_id == idle_id) begin
      code = sdwq_pkg::ST_IDLE_THR;
    end else if (count == CW'(QUEUE_DEPTH)) begin
      code = sdwq_pkg::ST_FULL;
    end else begin
      code = sdwq_pkg::ST_OK;
    end
  end

  assign raddr = cmd.rd_head ? head : prev_phys;
  assign wr_entry = cmd.shift ? rd_entry
                              : sdwq_pkg::entry_t'{deadline: new_dl, thread: req.thread_id};

  sdwq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH),
    .ADDR_W(AW)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.shift | cmd.ins),
    .waddr(pos_phys),
    .wdata(wr_entry),
    .re   (cmd.rd_head | cmd.rd_prev),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign st.is_sleep   = (req.mode == sdwq_pkg::MODE_SLEEP);
  assign st.sleep_code = code;
  assign st.count_zero = (count == '0);
  assign st.pos_zero   = (pos == '0);
  assign st.rd_le      = (rd_entry.deadline <= new_dl);
  assign st.due        = (rd_entry.deadline <= tick_count);
  assign st.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      count      <= '0;
      head       <= '0;
      idle_id    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        idle_id <= cfg_data;
      end
      if (cmd.tick_inc) begin
        tick_count <= tick_count + 64'd1;
      end
      if (cmd.ins) begin
        count <= count + 1'b1;
      end else if (cmd.pop) begin
        count <= count - 1'b1;
        head  <= head_inc;
      end
      if (cmd.emit_ans || cmd.emit_wake) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req    <= in_data;
      queued <= 1'b0;
    end else if (cmd.ins) begin
      queued <= 1'b1;
    end
    if (cmd.calc_dl) begin
      new_dl   <= dl_sum[64] ? '1 : dl_sum[63:0];
      pos      <= count;
      pos_phys <= tail;
    end else if (cmd.shift) begin
      pos      <= pos - 1'b1;
      pos_phys <= prev_phys;
    end
    if (cmd.pop) begin
      pend_id <= rd_entry.thread;
    end
    // count has already moved on for a queued request, so its code is fixed
    if (cmd.emit_ans) begin
      out_data <= '{kind: sdwq_pkg::KIND_ANS, woken_or_req_id: req.thread_id,
                    status: queued ? sdwq_pkg::ST_OK : code, last: 1'b1};
    end else if (cmd.emit_wake) begin
      out_data <= '{kind: sdwq_pkg::KIND_WAKE, woken_or_req_id: pend_id,
                    status: sdwq_pkg::ST_OK, last: cmd.emit_last};
    end
  end

endmodule
`default_nettype wire

### tb/sv/tb_sleep_deadline_wakeup_queue.sv
`default_nettype none
// Self-checking bench for the sorted timer wake-up queue.
// A behavioral copy of the queue (tick count, sorted sleepers, idle id) is
// advanced on every accepted input transfer and pushes the replies it
// predicts. Every result transfer is checked field by field against the
// oldest predicted reply.
module tb_sleep_deadline_wakeup_queue;

  localparam int CLK_LIMIT     = 1_000_000;  // far above the slowest legal run
  localparam int SETTLE_CYCLES = 60;         // idle wait after the last owed reply
  localparam int N_SLOTS       = sdwq_pkg::QUEUE_DEPTH_DEF;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  sdwq_pkg::in_item_t   in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  sdwq_pkg::out_item_t  out_data;
  logic                 cfg_we = 1'b0;
  logic [7:0]           cfg_data = '0;

  // Behavioral queue state, mirrors the block.
  logic [63:0] mdl_now;
  logic [7:0]  mdl_idle_id;
  logic [63:0] sleeper_dl[$];
  logic [7:0]  sleeper_id[$];

  // Replies still owed by the block: wake-ups and request answers, in order.
  sdwq_pkg::out_item_t reply_fifo[$];
  sdwq_pkg::out_item_t want;

  int          err_count   = 0;
  int          cycle_count = 0;
  int          n_sent      = 0;
  // Bubble controls: quiet kills all idling for the final stretch.
  bit          quiet      = 1'b0;
  bit          tx_bubbles = 1'b1;
  bit          rx_bubbles = 1'b1;
  int          stall_left = 0;

  sleep_deadline_wakeup_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CLK_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Advance the behavioral queue by one input transfer and queue its replies.
  function automatic void compute_replies(input sdwq_pkg::in_item_t it);
    sdwq_pkg::out_item_t r;
    sdwq_pkg::out_item_t woke[$];
    logic [64:0]         sum;
    logic [63:0]         dl;
    int                  pos;
    if (it.mode == sdwq_pkg::MODE_TICK) begin
      mdl_now = mdl_now + 64'd1;
      // front entries that are due, at most WAKE_LIMIT per tick
      while (woke.size() < sdwq_pkg::WAKE_LIMIT && sleeper_dl.size() > 0 &&
             sleeper_dl[0] <= mdl_now) begin
        r.kind            = sdwq_pkg::KIND_WAKE;
        r.woken_or_req_id = sleeper_id[0];
        r.status          = sdwq_pkg::ST_OK;
        r.last            = 1'b0;
        woke.push_back(r);
        void'(sleeper_dl.pop_front());
        void'(sleeper_id.pop_front());
      end
      if (woke.size() > 0) woke[woke.size() - 1].last = 1'b1;
      foreach (woke[i]) reply_fifo.push_back(woke[i]);
    end else begin
      r.kind            = sdwq_pkg::KIND_ANS;
      r.woken_or_req_id = it.thread_id;
      r.last            = 1'b1;
      // check order matters: zero and negative win over the idle thread
      if (it.sleep_ticks == 32'sd0) begin
        r.status = sdwq_pkg::ST_YIELD;
      end else if (it.sleep_ticks[31]) begin
        r.status = sdwq_pkg::ST_NEGATIVE;
      end else if (it.thread_id == mdl_idle_id) begin
        r.status = sdwq_pkg::ST_IDLE_THR;
      end else if (sleeper_dl.size() >= N_SLOTS) begin
        r.status = sdwq_pkg::ST_FULL;
      end else begin
        sum = {1'b0, mdl_now} + {33'd0, it.sleep_ticks[31:0]};
        dl  = sum[64] ? '1 : sum[63:0];  // saturate at the top
        // stable insert: behind every equal or earlier deadline
        pos = 0;
        while (pos < sleeper_dl.size() && sleeper_dl[pos] <= dl) pos++;
        sleeper_dl.insert(pos, dl);
        sleeper_id.insert(pos, it.thread_id);
        r.status = sdwq_pkg::ST_OK;
      end
      reply_fifo.push_back(r);
    end
  endfunction

  function automatic sdwq_pkg::in_item_t make_sleep(input logic [7:0] id,
                                                    input logic [31:0] ticks);
    sdwq_pkg::in_item_t it;
    it.mode        = sdwq_pkg::MODE_SLEEP;
    it.thread_id   = id;
    it.sleep_ticks = ticks;
    return it;
  endfunction

  // Tick transfer; the unused fields carry noise.
  function automatic sdwq_pkg::in_item_t make_tick();
    sdwq_pkg::in_item_t it;
    it.mode        = sdwq_pkg::MODE_TICK;
    it.thread_id   = 8'($urandom);
    it.sleep_ticks = $urandom;
    return it;
  endfunction

  // Any thread id except the idle one.
  function automatic logic [7:0] busy_id();
    logic [7:0] id;
    id = 8'($urandom_range(0, 255));
    if (id == mdl_idle_id) id = id ^ 8'h01;
    return id;
  endfunction

  // One input transfer. Called at a rising edge; returns at the accepting
  // edge with valid left high so back-to-back transfers need no toggle.
  task automatic send_item(input sdwq_pkg::in_item_t it);
    if (!quiet && tx_bubbles && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    compute_replies(it);
    n_sent++;
  endtask

  // Hold off until every owed reply is in and the block has run dry.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (reply_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle_thread(input logic [7:0] id);
    settle_block();
    cfg_we   <= 1'b1;
    cfg_data <= id;
    @(posedge clk);
    cfg_we   <= 1'b0;
    mdl_idle_id = id;
  endtask

  // Tick until every sleeper has woken.
  task automatic drain_sleepers();
    while (sleeper_dl.size() != 0) send_item(make_tick());
  endtask

  // Answers for each request class; idle thread is 0 out of reset, and
  // zero / negative ticks must beat the idle check.
  task automatic test_request_answers();
    send_item(make_sleep(8'd0, 32'd0));            // yield, even for idle thread
    send_item(make_sleep(8'd0, 32'hFFFF_FFFF));    // -1, even for idle thread
    send_item(make_sleep(8'd0, 32'd5));            // idle thread ignored
    send_item(make_sleep(8'd255, 32'h8000_0000));  // most negative
    send_item(make_sleep(8'd255, 32'd1));          // queued
    send_item(make_tick());                        // wakes 255
    send_item(make_tick());                        // nothing due, no result
  endtask

  // Equal deadlines keep arrival order; a same id may sleep twice.
  task automatic test_equal_deadlines();
    send_item(make_sleep(8'd1, 32'd3));
    send_item(make_sleep(8'd2, 32'd3));
    send_item(make_sleep(8'd3, 32'd2));
    send_item(make_sleep(8'd1, 32'd3));
    repeat (3) send_item(make_tick());
  endtask

  task automatic test_idle_register();
    set_idle_thread(8'd255);
    send_item(make_sleep(8'd255, 32'd2));  // now ignored as idle
    send_item(make_sleep(8'd0, 32'd1));    // id 0 is a normal thread now
    send_item(make_tick());
  endtask

  // Fill an empty queue with one deadline, overflow it, wake all at once.
  task automatic test_wake_burst();
    drain_sleepers();
    repeat (N_SLOTS + 1) send_item(make_sleep(busy_id(), 32'd1));
    send_item(make_tick());
  endtask

  // Mixed traffic at one idle id setting.
  task automatic test_random_mix(input int count, input logic [7:0] idle_id);
    int         pick;
    logic [7:0] id;
    set_idle_thread(idle_id);
    repeat (count) begin
      // flip bubble modes now and then so quiet stretches appear too
      if ($urandom_range(0, 29) == 0) tx_bubbles = ~tx_bubbles;
      if ($urandom_range(0, 29) == 0) rx_bubbles = ~rx_bubbles;
      pick = $urandom_range(0, 99);
      id   = 8'($urandom_range(0, 255));
      if (pick < 40)      send_item(make_sleep(id, 32'($urandom_range(1, 20))));
      else if (pick < 75) send_item(make_tick());
      else if (pick < 80) send_item(make_sleep(id, 32'd0));
      else if (pick < 86) send_item(make_sleep(id, $urandom | 32'h8000_0000));
      else if (pick < 92) send_item(make_sleep(mdl_idle_id, 32'($urandom_range(1, 30))));
      else                send_item(make_sleep(id, 32'($urandom_range(1, 3))));
    end
  endtask

  // Largest positive sleep: sits at the tail for the rest of the run.
  task automatic test_far_deadline();
    drain_sleepers();
    send_item(make_sleep(busy_id(), 32'h7FFF_FFFF));
    send_item(make_tick());
  endtask

  // Consumer side stall: random bursts of out_stall.
  always @(posedge clk) begin
    if (rst || quiet || !rx_bubbles) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker: each result transfer against the oldest owed reply.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (reply_fifo.size() == 0) begin
        flag_error($sformatf("unrequested result %p", out_data));
      end else begin
        want = reply_fifo.pop_front();
        if (out_data.kind !== want.kind)
          flag_error($sformatf("kind %b, want %b", out_data.kind, want.kind));
        if (out_data.woken_or_req_id !== want.woken_or_req_id)
          flag_error($sformatf("id %0d, want %0d",
                               out_data.woken_or_req_id, want.woken_or_req_id));
        if (out_data.status !== want.status)
          flag_error($sformatf("status %0d, want %0d", out_data.status, want.status));
        if (out_data.last !== want.last)
          flag_error($sformatf("last %b, want %b", out_data.last, want.last));
      end
    end
  end

  initial begin
    mdl_now     = '0;
    mdl_idle_id = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_request_answers();
    test_equal_deadlines();
    test_idle_register();
    test_random_mix(80, 8'd255);
    test_wake_burst();
    test_random_mix(80, 8'($urandom_range(1, 254)));
    test_random_mix(80, 8'd0);
    // final stretch runs without bubbles on either side
    quiet = 1'b1;
    test_random_mix(80, 8'($urandom_range(0, 255)));
    test_far_deadline();

    settle_block();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
hw/rtl/sdwq_pkg.sv
hw/rtl/sdwq_ram.sv
hw/rtl/sdwq_ctrl.sv
hw/rtl/sdwq_dp.sv
hw/rtl/sleep_deadline_wakeup_queue.sv
tb/sv/tb_sleep_deadline_wakeup_queue.sv
